[design/rgb565_blitter_with_key_and_alpha_assert.svh]
// Assertion macros shared by the blitter RTL.
// Assertions compile only when SYNTHESIS is not defined; otherwise they vanish.
`ifndef RGB565_BLITTER_WITH_KEY_AND_ALPHA_ASSERT_SVH
`define RGB565_BLITTER_WITH_KEY_AND_ALPHA_ASSERT_SVH
`ifndef SYNTHESIS
// The condition on the right must hold in the same cycle as the one on the left.
`define BLT_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("blitter assertion failed");
// The condition on the right must hold in the cycle after the one on the left.
`define BLT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("blitter assertion failed");
`else
`define BLT_ASSERT_SAME(label, clk, rst, pre, post)
`define BLT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[design/rgbblt_pkg.sv]
// Shared constants of the RGB565 blitter: field widths, command and register codes.
// No dependencies.
`default_nettype none

package rgbblt_pkg;

  localparam int WIDTH_DEF  = 256;
  localparam int HEIGHT_DEF = 256;

  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam int PIX_W   = 16;
  localparam int CMD_W   = 3;
  localparam int ALPHA_W = 8;
  localparam int POS_W   = 8;
  localparam int SIZE_W  = 9;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COPY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KBLEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CBLEND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_KEY   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FG    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RY    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RW    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RH    = 3'd6;

endpackage

`default_nettype wire

[design/rgbblt_in_if.sv]
// Input channel of the blitter: one drawing or scan-out command per transfer.
// Depends on rgbblt_pkg.
`default_nettype none

interface rgbblt_in_if import rgbblt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [PIX_W-1:0]   source_pixel;
  logic [ALPHA_W-1:0] coverage;

  modport source (output valid, command, source_pixel, coverage, input ready);
  modport sink (input valid, command, source_pixel, coverage, output ready);
endinterface

`default_nettype wire

[design/rgbblt_out_if.sv]
// Output channel of the blitter: one scanned-out pixel per transfer.
// Depends on rgbblt_pkg.
`default_nettype none

interface rgbblt_out_if import rgbblt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_end;

  modport source (output valid, pixel, frame_end, input ready);
  modport sink (input valid, pixel, frame_end, output ready);
endinterface

`default_nettype wire

[design/rgbblt_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module rgbblt_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/rgbblt_blend.sv]
// Per-channel RGB565 alpha mix: registers the weighted sums, then divides by 255.
// Depends on rgbblt_pkg.
`default_nettype none

module rgbblt_blend import rgbblt_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [PIX_W-1:0]   bg,
  input  logic [PIX_W-1:0]   fg,
  input  logic [ALPHA_W-1:0] alpha,
  output logic [PIX_W-1:0]   result
);

  localparam int SUM_W = 14;

  // Floor of s/255 for s below 64*255, without a divider.
  function automatic logic [5:0] div255(input logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(s[SUM_W-1:8]) + (SUM_W+1)'(1);
    return t[SUM_W-1:8];
  endfunction

  logic [ALPHA_W-1:0] alpha_inv;
  logic [SUM_W-1:0]   red_sum;
  logic [SUM_W-1:0]   green_sum;
  logic [SUM_W-1:0]   blue_sum;
  logic [5:0]         red_q;
  logic [5:0]         green_q;
  logic [5:0]         blue_q;

  assign alpha_inv = 8'd255 - alpha;

  always_ff @(posedge clk) begin
    if (load) begin
      red_sum   <= SUM_W'(bg[15:11]) * SUM_W'(alpha_inv) + SUM_W'(fg[15:11]) * SUM_W'(alpha);
      green_sum <= SUM_W'(bg[10:5]) * SUM_W'(alpha_inv) + SUM_W'(fg[10:5]) * SUM_W'(alpha);
      blue_sum  <= SUM_W'(bg[4:0]) * SUM_W'(alpha_inv) + SUM_W'(fg[4:0]) * SUM_W'(alpha);
    end
  end

  assign red_q   = div255(red_sum);
  assign green_q = div255(green_sum);
  assign blue_q  = div255(blue_sum);

  assign result = {red_q[4:0], green_q, blue_q[4:0]};

endmodule

`default_nettype wire

[design/rgb565_blitter_with_key_and_alpha.sv]
// RGB565 blitter top level. Fill and keyed copy write the frame store at the transfer; keyed blend
// and coverage blend go through frame store read, weighted-sum register and write back;
// scan-out reads the frame store and then waits until the output register is free.
// Reset is synchronous and active high. After reset a clearing pass writes zero to all
// 65536 frame store entries, one per cycle, and no command is taken during those cycles;
// configuration writes are taken at all times.
`default_nettype none

`include "rgb565_blitter_with_key_and_alpha_assert.svh"

module rgb565_blitter_with_key_and_alpha import rgbblt_pkg::*; #(
  parameter int WIDTH  = WIDTH_DEF,
  parameter int HEIGHT = HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  rgbblt_in_if.sink           pix_in,
  rgbblt_out_if.source        pix_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Linear address y*WIDTH + x needs this many bits before it is folded into the store.
  localparam int MULW = SIZE_W + $clog2(WIDTH + 1);
  localparam int LINW = (MULW + 1 > STORE_AW) ? MULW + 1 : STORE_AW;
  // The scan-out frame covers WIDTH*HEIGHT pixels, but never more than the store holds.
  localparam int FRAME_LEN = (WIDTH * HEIGHT > STORE_DEPTH) ? STORE_DEPTH : WIDTH * HEIGHT;
  localparam logic [STORE_AW-1:0] FRAME_LAST = STORE_AW'(FRAME_LEN - 1);

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_WR, S_SCAN} state_t;

  // Rectangle size minus one, with zero treated as one and anything above 256 as 256.
  function automatic logic [POS_W-1:0] size_m1(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (v[SIZE_W-1]) begin
      return '1;
    end else begin
      return POS_W'(v - SIZE_W'(1));
    end
  endfunction

  // Configuration registers.
  logic [PIX_W-1:0]   key_color;
  logic [ALPHA_W-1:0] blend_alpha;
  logic [PIX_W-1:0]   fg_color;
  logic [POS_W-1:0]   rect_x;
  logic [POS_W-1:0]   rect_y;
  logic [SIZE_W-1:0]  rect_w;
  logic [SIZE_W-1:0]  rect_h;

  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 rect_wr;

  // Cursor inside the rectangle and scan-out position.
  logic [POS_W-1:0]    cur_col;
  logic [POS_W-1:0]    cur_row;
  logic [STORE_AW-1:0] scan_addr;
  logic                scan_end;

  // Clearing pass after reset.
  logic                clr_active;
  logic [STORE_AW-1:0] clr_addr;

  state_t state;

  // Operands of a blend that is in flight.
  logic [STORE_AW-1:0] op_addr;
  logic [PIX_W-1:0]    op_fg;
  logic [ALPHA_W-1:0]  op_alpha;

  logic                out_valid;
  logic [PIX_W-1:0]    out_pixel;
  logic                out_frame_end;
  logic                scan_load;

  logic                in_accept;
  logic                draw_accept;
  logic                key_hit;
  logic                blend_go;
  logic [SIZE_W-1:0]   x_pos;
  logic [SIZE_W-1:0]   y_pos;
  logic [LINW-1:0]     lin_addr;
  logic [STORE_AW-1:0] draw_addr;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [PIX_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [STORE_AW-1:0] ram_raddr;
  logic [PIX_W-1:0]    ram_rdata;
  logic [PIX_W-1:0]    blend_result;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied high.
  // Any write to the rectangle registers puts the cursor back at the origin.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign rect_wr = cfg_we && (cfg_idx inside {[REG_RX:REG_RH]});

  always_ff @(posedge clk) begin
    if (rst) begin
      key_color   <= '0;
      blend_alpha <= 8'd255;
      fg_color    <= 16'hFFFF;
      rect_x      <= '0;
      rect_y      <= '0;
      rect_w      <= 9'd256;
      rect_h      <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY:   key_color   <= pwdata[PIX_W-1:0];
        REG_ALPHA: blend_alpha <= pwdata[ALPHA_W-1:0];
        REG_FG:    fg_color    <= pwdata[PIX_W-1:0];
        REG_RX:    rect_x      <= pwdata[POS_W-1:0];
        REG_RY:    rect_y      <= pwdata[POS_W-1:0];
        REG_RW:    rect_w      <= pwdata[SIZE_W-1:0];
        REG_RH:    rect_h      <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KEY:   prdata = PDATA_W'(key_color);
      REG_ALPHA: prdata = PDATA_W'(blend_alpha);
      REG_FG:    prdata = PDATA_W'(fg_color);
      REG_RX:    prdata = PDATA_W'(rect_x);
      REG_RY:    prdata = PDATA_W'(rect_y);
      REG_RW:    prdata = PDATA_W'(rect_w);
      REG_RH:    prdata = PDATA_W'(rect_h);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Command intake. Commands are taken only in the idle state once the clearing
  // pass is over. Fill and keyed copy write the store in the cycle of their
  // transfer; a keyed item whose source equals the key writes nothing but still
  // moves the cursor.
  // ---------------------------------------------------------------------------
  assign pix_in.ready = (state == S_IDLE) && !clr_active;
  assign in_accept    = pix_in.valid && pix_in.ready;
  assign draw_accept  = in_accept && (pix_in.command <= CMD_CBLEND);
  assign key_hit      = (pix_in.source_pixel == key_color);
  assign blend_go     = in_accept &&
                        (((pix_in.command == CMD_KBLEND) && !key_hit) ||
                         (pix_in.command == CMD_CBLEND));

  // Store address of the pixel under the cursor, folded to the store size.
  assign x_pos     = SIZE_W'(rect_x) + SIZE_W'(cur_col);
  assign y_pos     = SIZE_W'(rect_y) + SIZE_W'(cur_row);
  assign lin_addr  = LINW'(y_pos) * LINW'(WIDTH) + LINW'(x_pos);
  assign draw_addr = lin_addr[STORE_AW-1:0];

  // Cursor walks the rectangle in raster order and wraps to its origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (rect_wr) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (draw_accept) begin
      if (cur_col == size_m1(rect_w)) begin
        cur_col <= '0;
        cur_row <= (cur_row == size_m1(rect_h)) ? '0 : cur_row + POS_W'(1);
      end else begin
        cur_col <= cur_col + POS_W'(1);
      end
    end
  end

  // Scan-out position runs over the whole frame and wraps after its last pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (in_accept && (pix_in.command == CMD_SCAN)) begin
      scan_addr <= (scan_addr == FRAME_LAST) ? '0 : scan_addr + STORE_AW'(1);
    end
  end

  // Operands captured at the transfer, used in the later cycles of a blend or scan-out.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_addr  <= draw_addr;
      scan_end <= (scan_addr == FRAME_LAST);
      if (pix_in.command == CMD_CBLEND) begin
        op_fg    <= fg_color;
        op_alpha <= pix_in.coverage;
      end else begin
        op_fg    <= pix_in.source_pixel;
        op_alpha <= blend_alpha;
      end
    end
  end

  // Clearing pass: one entry per cycle from address zero to the top of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + STORE_AW'(1);
      if (clr_addr == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store port control. Only one item is in flight at a time, so the
  // blend write-back always finishes before the next item reads the store.
  // During a scan-out the read port is left alone so the read data holds until
  // the output register is free.
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = draw_addr;
    ram_wdata = pix_in.source_pixel;
    ram_re    = 1'b0;
    ram_raddr = draw_addr;
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_WR) begin
      ram_we    = 1'b1;
      ram_waddr = op_addr;
      ram_wdata = blend_result;
    end else if (in_accept) begin
      unique case (pix_in.command) inside
        CMD_FILL:               ram_we = 1'b1;
        CMD_COPY:               ram_we = !key_hit;
        CMD_KBLEND, CMD_CBLEND: ram_re = blend_go;
        CMD_SCAN: begin
          ram_re    = 1'b1;
          ram_raddr = scan_addr;
        end
        default: ;
      endcase
    end
  end

  rgbblt_ram #(
    .DW    (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The stored pixel arrives in the mix state; the blend unit registers the
  // weighted sums there and presents the divided result in the write state.
  rgbblt_blend u_blend (
    .clk    (clk),
    .load   (state == S_MIX),
    .bg     (ram_rdata),
    .fg     (op_fg),
    .alpha  (op_alpha),
    .result (blend_result)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register. A scan-out result waits in the output
  // register while new commands are taken; a second scan-out holds in its
  // read state until that register has been emptied.
  // ---------------------------------------------------------------------------
  // The read data of a scan-out moves into the output register once that register
  // is empty or is being emptied in the same cycle.
  assign scan_load = (state == S_SCAN) && (!out_valid || pix_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (scan_load) begin
        out_valid     <= 1'b1;
        out_pixel     <= ram_rdata;
        out_frame_end <= scan_end;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (blend_go) begin
            state <= S_MIX;
          end else if (in_accept && (pix_in.command == CMD_SCAN)) begin
            state <= S_SCAN;
          end
        end
        S_MIX: state <= S_WR;
        S_WR:  state <= S_IDLE;
        S_SCAN: begin
          if (scan_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.pixel     = out_pixel;
  assign pix_out.frame_end = out_frame_end;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A blend transfer goes to the mix state and the store is not written meanwhile.
  `BLT_ASSERT_NEXT(a_blend_enters_mix, clk, rst, blend_go, (state == S_MIX) && !ram_we)
  // The read data must hold while a scan-out waits for the output register.
  `BLT_ASSERT_SAME(a_scan_port_quiet, clk, rst, state == S_SCAN, !ram_re && !ram_we)
  // The scan-out position wraps to zero right after the frame's last pixel.
  `BLT_ASSERT_NEXT(a_scan_wraps, clk, rst,
                   in_accept && (pix_in.command == CMD_SCAN) && (scan_addr == FRAME_LAST),
                   scan_addr == '0)
  // The clearing pass ends only after it has wrapped past the top entry.
  `BLT_ASSERT_SAME(a_clear_complete, clk, rst, $fell(clr_active), clr_addr == '0)

endmodule

`default_nettype wire
